/* rtl/rrbs_pkg.sv */
// Package with shared constants and types for the radiance region bin splitter.
package rrbs_pkg;
  localparam int MaxWidthDefault = 256;
  localparam int MaxHeightDefault = 128;
  localparam int StackDepthDefault = 16;
  localparam int ChannelBitsDefault = 32;
  localparam int CfgIndexBits = 2;
  localparam int CfgDataBits = 32;

  typedef enum logic [1:0] {
    ACT_LOAD    = 2'd0,
    ACT_FETCH   = 2'd1,
    ACT_RESTART = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_RADIANCE = 2'd2,
    REG_AREA   = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [8:0]  image_width;
    logic [7:0]  image_height;
    logic [31:0] min_radiance;
    logic [15:0] smallest_bin_area;
  } cfg_t;

  typedef struct packed {
    logic [31:0] red;
    logic [31:0] green;
    logic [31:0] blue;
  } pixel_t;
endpackage

/* rtl/rrbs_if.sv */
// Valid/ready channel interfaces for the input and result words.
interface rrbs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] red;
  logic [31:0] green;
  logic [31:0] blue;
  modport source (output valid, action, red, green, blue, input ready);
  modport sink (input valid, action, red, green, blue, output ready);
endinterface

interface rrbs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] bin_x_first;
  logic [7:0] bin_x_last;
  logic [6:0] bin_y_first;
  logic [6:0] bin_y_last;
  logic       last_bin;
  logic       no_bin;
  modport source (output valid, bin_x_first, bin_x_last, bin_y_first, bin_y_last,
                  last_bin, no_bin, input ready);
  modport sink (input valid, bin_x_first, bin_x_last, bin_y_first, bin_y_last,
                last_bin, no_bin, output ready);
endinterface

/* rtl/rrbs_sum_unit.sv */
// Shared accumulator that sums pixel channels and tests the radiance length.
module rrbs_sum_unit
  import rrbs_pkg::*;
(
  input  logic        clk,
  input  logic        clear,
  input  logic        add_en,
  input  pixel_t      pix,
  input  logic        sq_en,
  input  logic [1:0]  sq_sel,
  input  logic        lim_en,
  input  logic [31:0] min_radiance,
  output logic        is_dim
);
  logic [47:0] sum_r, sum_g, sum_b;
  logic [63:0] acc, lim;
  logic        over;
  logic [47:0] sel;
  logic [63:0] sq;

  always_comb begin
    case (sq_sel)
      2'd0: sel = sum_r;
      2'd1: sel = sum_g;
      2'd2: sel = sum_b;
      default: sel = 48'(min_radiance);
    endcase
    sq = 64'(sel[31:0]) * 64'(sel[31:0]);
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      sum_r <= '0;
      sum_g <= '0;
      sum_b <= '0;
      acc <= '0;
      over <= 1'b0;
    end else if (add_en) begin
      sum_r <= sum_r + 48'(pix.red);
      sum_g <= sum_g + 48'(pix.green);
      sum_b <= sum_b + 48'(pix.blue);
    end else if (sq_en) begin
      if (sel[47:32] != '0) begin
        over <= 1'b1;
      end else if ({1'b0, acc} + {1'b0, sq} > 65'h0_FFFF_FFFF_FFFF_FFFF) begin
        over <= 1'b1;
      end else begin
        acc <= acc + sq;
      end
    end
    if (lim_en) begin
      lim <= sq;
    end
  end

  assign is_dim = !over && (acc <= lim);
endmodule

/* rtl/radiance_region_bin_splitter.sv */
// Top level of the radiance region bin splitter: image store, region stack, sequencer.
//  channel  | dir | handshake   | word
//  in_ch    | in  | valid/ready | action, red, green, blue
//  out_ch   | out | valid/ready | bin bounds, last_bin, no_bin
//  cfg      | in  | cfg_we      | cfg_index, cfg_data
// Loads may follow back to back.
// A fetch pops regions from the stack; each region it sums is read at one store read per
// cycle into the shared accumulator, a region that stops without a sum goes from the
// test straight to the output state, and the bin is registered there.
// Reset clears control state and sets the configuration to its defaults; the image store is not cleared.
// The block accepts no word while a fetch runs or a result waits to be taken.
module radiance_region_bin_splitter
  import rrbs_pkg::*;
#(
  parameter int MAX_WIDTH = MaxWidthDefault,
  parameter int MAX_HEIGHT = MaxHeightDefault,
  parameter int STACK_DEPTH = StackDepthDefault,
  parameter int CHANNEL_BITS = ChannelBitsDefault
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CfgIndexBits-1:0] cfg_index,
  input  logic [CfgDataBits-1:0]  cfg_data,
  rrbs_in_if.sink                 in_ch,
  rrbs_out_if.source              out_ch
);
  localparam int StoreSize = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW = $clog2(StoreSize);
  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int SW = $clog2(STACK_DEPTH);
  localparam int CW = SW + 1;
  localparam logic [31:0] ChanMax = 32'hFFFF_FFFF >> (32 - CHANNEL_BITS);

  typedef struct packed {
    logic [XW-1:0] x0;
    logic [XW-1:0] x1;
    logic [YW-1:0] y0;
    logic [YW-1:0] y1;
  } region_t;

  typedef enum logic [3:0] {
    S_IDLE, S_POP, S_READ, S_TEST, S_SUM, S_DRAIN, S_SQ, S_DECIDE, S_OUT
  } state_t;

  state_t state;
  cfg_t cfg;
  pixel_t store [StoreSize];
  pixel_t rd_pix;
  region_t stack [STACK_DEPTH];
  region_t reg_cur;
  logic [CW-1:0] count;
  logic [AW:0] load_index;
  logic started;
  logic [XW-1:0] cx;
  logic [YW-1:0] cy;
  logic [1:0] sq_sel;
  logic rd_valid, rd_in_range;
  logic [XW:0] eff_w;
  logic [YW:0] eff_h;
  logic [AW:0] total;
  logic [XW:0] rw;
  logic [YW:0] rh;
  logic [AW:0] area;
  logic [AW+XW+1:0] addr_full;
  logic sum_clear, sum_add, sum_sq, sum_lim, is_dim;

  always_comb begin
    if (cfg.image_width == '0) eff_w = (XW+1)'(1);
    else if (32'(cfg.image_width) > MAX_WIDTH) eff_w = (XW+1)'(MAX_WIDTH);
    else eff_w = (XW+1)'(cfg.image_width);
    if (cfg.image_height == '0) eff_h = (YW+1)'(1);
    else if (32'(cfg.image_height) > MAX_HEIGHT) eff_h = (YW+1)'(MAX_HEIGHT);
    else eff_h = (YW+1)'(cfg.image_height);
    total = (AW+1)'(eff_w) * (AW+1)'(eff_h);
    rw = (XW+1)'(reg_cur.x1) - (XW+1)'(reg_cur.x0) + 1'b1;
    rh = (YW+1)'(reg_cur.y1) - (YW+1)'(reg_cur.y0) + 1'b1;
    area = (AW+1)'(rw) * (AW+1)'(rh);
    addr_full = (AW+XW+2)'(cx) + (AW+XW+2)'(cy) * (AW+XW+2)'(eff_w);
  end

  assign in_ch.ready = (state == S_IDLE) && !out_ch.valid;
  assign sum_clear = (state == S_READ);
  assign sum_add = (state == S_SUM || state == S_DRAIN) && rd_valid && rd_in_range;
  assign sum_sq = (state == S_SQ);
  assign sum_lim = (state == S_READ);

  rrbs_sum_unit u_sum (
    .clk, .clear(sum_clear), .add_en(sum_add), .pix(rd_pix), .sq_en(sum_sq),
    .sq_sel, .lim_en(sum_lim), .min_radiance(cfg.min_radiance), .is_dim
  );

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready && in_ch.action == ACT_LOAD
        && load_index < total && load_index < (AW+1)'(StoreSize)) begin
      store[load_index[AW-1:0]] <= '{
        (in_ch.red > ChanMax) ? ChanMax : in_ch.red,
        (in_ch.green > ChanMax) ? ChanMax : in_ch.green,
        (in_ch.blue > ChanMax) ? ChanMax : in_ch.blue};
    end
    rd_pix <= store[addr_full[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{9'd256, 8'd128, 32'd65536, 16'd1};
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_WIDTH: cfg.image_width <= cfg_data[8:0];
        REG_HEIGHT: cfg.image_height <= cfg_data[7:0];
        REG_RADIANCE: cfg.min_radiance <= cfg_data;
        REG_AREA: cfg.smallest_bin_area <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      load_index <= '0;
      count <= '0;
      started <= 1'b0;
      out_ch.valid <= 1'b0;
      rd_valid <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            unique case (action_t'(in_ch.action))
              ACT_LOAD: begin
                if (load_index < total && load_index < (AW+1)'(StoreSize))
                  load_index <= load_index + 1'b1;
              end
              ACT_RESTART: begin
                load_index <= '0;
                count <= '0;
                started <= 1'b0;
              end
              ACT_FETCH: begin
                out_ch.bin_x_first <= '0;
                out_ch.bin_x_last <= '0;
                out_ch.bin_y_first <= '0;
                out_ch.bin_y_last <= '0;
                out_ch.last_bin <= 1'b0;
                if (load_index < total) begin
                  out_ch.no_bin <= 1'b1;
                  out_ch.valid <= 1'b1;
                end else begin
                  if (!started) begin
                    started <= 1'b1;
                    stack[0] <= '{'0, XW'(eff_w - 1'b1), '0, YW'(eff_h - 1'b1)};
                    count <= CW'(1);
                  end
                  state <= S_POP;
                end
              end
              default: ;
            endcase
          end
        end
        S_POP: begin
          if (count == '0) begin
            out_ch.no_bin <= 1'b1;
            out_ch.valid <= 1'b1;
            state <= S_IDLE;
          end else begin
            count <= count - 1'b1;
            reg_cur <= stack[SW'(count - 1'b1)];
            state <= S_TEST;
          end
        end
        S_TEST: begin
          if (area == (AW+1)'(1) || 32'(area) <= 32'(cfg.smallest_bin_area)
              || 32'(count) + 2 > STACK_DEPTH) begin
            state <= S_OUT;
          end else begin
            cx <= reg_cur.x0;
            cy <= reg_cur.y0;
            sq_sel <= 2'd3;
            state <= S_READ;
          end
        end
        S_READ: begin
          rd_in_range <= addr_full < (AW+XW+2)'(StoreSize);
          rd_valid <= 1'b1;
          if (cx == reg_cur.x1) begin
            cx <= reg_cur.x0;
            if (cy == reg_cur.y1) state <= S_DRAIN;
            else begin
              cy <= cy + 1'b1;
              state <= S_SUM;
            end
          end else begin
            cx <= cx + 1'b1;
            state <= S_SUM;
          end
        end
        S_SUM: begin
          rd_in_range <= addr_full < (AW+XW+2)'(StoreSize);
          if (cx == reg_cur.x1) begin
            cx <= reg_cur.x0;
            if (cy == reg_cur.y1) state <= S_DRAIN;
            else cy <= cy + 1'b1;
          end else begin
            cx <= cx + 1'b1;
          end
        end
        S_DRAIN: begin
          rd_valid <= 1'b0;
          sq_sel <= 2'd0;
          state <= S_SQ;
        end
        S_SQ: begin
          if (sq_sel == 2'd2) state <= S_DECIDE;
          else sq_sel <= sq_sel + 1'b1;
        end
        S_DECIDE: begin
          if (is_dim) begin
            state <= S_OUT;
          end else begin
            if (rw > (XW+1)'(rh)) begin
              stack[SW'(count)] <= '{XW'((rw - 1'b1) >> 1) + reg_cur.x0 + 1'b1,
                                    reg_cur.x1, reg_cur.y0, reg_cur.y1};
              stack[SW'(count + 1'b1)] <= '{reg_cur.x0,
                                    XW'((rw - 1'b1) >> 1) + reg_cur.x0,
                                    reg_cur.y0, reg_cur.y1};
            end else begin
              stack[SW'(count)] <= '{reg_cur.x0, reg_cur.x1,
                                    YW'((rh - 1'b1) >> 1) + reg_cur.y0 + 1'b1, reg_cur.y1};
              stack[SW'(count + 1'b1)] <= '{reg_cur.x0, reg_cur.x1, reg_cur.y0,
                                    YW'((rh - 1'b1) >> 1) + reg_cur.y0};
            end
            count <= count + 2'd2;
            state <= S_POP;
          end
        end
        S_OUT: begin
          out_ch.bin_x_first <= 8'(reg_cur.x0);
          out_ch.bin_x_last <= 8'(reg_cur.x1);
          out_ch.bin_y_first <= 7'(reg_cur.y0);
          out_ch.bin_y_last <= 7'(reg_cur.y1);
          out_ch.last_bin <= (count == '0);
          out_ch.no_bin <= 1'b0;
          out_ch.valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= STACK_DEPTH) else $error("stack count overflow");
  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !in_ch.ready) else $error("ready while busy");
  a_out_from_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) |-> state == S_IDLE) else $error("result raised while busy");
endmodule

/* dv/radiance_region_bin_splitter_test.sv */
// Testbench for the radiance region bin splitter: directed and random tests against a bin predictor.
`timescale 1ns / 100ps

module radiance_region_bin_splitter_test;
  import rrbs_pkg::*;

  localparam int StoreSize = MaxWidthDefault * MaxHeightDefault;
  localparam int CycleLimit = 3000000;
  localparam int RandomWords = 1700;

  typedef struct {
    bit [7:0] x_first;
    bit [7:0] x_last;
    bit [6:0] y_first;
    bit [6:0] y_last;
    bit       last;
    bit       none;
  } bin_word_t;

  typedef struct {
    int unsigned x0;
    int unsigned x1;
    int unsigned y0;
    int unsigned y1;
  } span_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CfgIndexBits-1:0] cfg_index;
  logic [CfgDataBits-1:0] cfg_data;

  rrbs_in_if in_ch ();
  rrbs_out_if out_ch ();

  radiance_region_bin_splitter uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  pixel_t pixel_copy[StoreSize];
  span_t span_stack[StackDepthDefault];
  int unsigned span_count;
  int unsigned pixels_loaded;
  bit splitting_started;
  cfg_t shadow_cfg;

  bin_word_t expected_bins[$];
  bit fetch_gave_none;
  bit quiet;
  int hold_off_cycles;
  int words_sent;
  int bins_checked;
  int bins_real;
  int errors;
  int cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles.", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int unsigned used_width();
    if (shadow_cfg.image_width == 0) return 1;
    if (shadow_cfg.image_width > MaxWidthDefault) return MaxWidthDefault;
    return shadow_cfg.image_width;
  endfunction

  function automatic int unsigned used_height();
    if (shadow_cfg.image_height == 0) return 1;
    if (shadow_cfg.image_height > MaxHeightDefault) return MaxHeightDefault;
    return shadow_cfg.image_height;
  endfunction

  function automatic bit region_is_dim(span_t r);
    longint unsigned sums[3];
    longint unsigned acc, sq, lim, a;
    int unsigned w;
    w = used_width();
    sums[0] = 0;
    sums[1] = 0;
    sums[2] = 0;
    acc = 0;
    for (longint unsigned y = r.y0; y <= r.y1; y++) begin
      for (longint unsigned x = r.x0; x <= r.x1; x++) begin
        a = x + y * w;
        if (a < StoreSize) begin
          sums[0] += pixel_copy[a].red;
          sums[1] += pixel_copy[a].green;
          sums[2] += pixel_copy[a].blue;
        end
      end
    end
    for (int c = 0; c < 3; c++) begin
      if (sums[c] > 64'hFFFF_FFFF) return 1'b0;
      sq = sums[c] * sums[c];
      if (acc > 64'hFFFF_FFFF_FFFF_FFFF - sq) return 1'b0;
      acc += sq;
    end
    lim = longint'(shadow_cfg.min_radiance) * longint'(shadow_cfg.min_radiance);
    return acc <= lim;
  endfunction

  function automatic void push_span(int unsigned x0, int unsigned x1, int unsigned y0,
                                    int unsigned y1);
    if (span_count >= StackDepthDefault) return;
    span_stack[span_count] = '{x0, x1, y0, y1};
    span_count++;
  endfunction

  function automatic bit predict_word(action_t act, pixel_t px, output bin_word_t res);
    int unsigned total;
    span_t r;
    longint unsigned w, h, area;
    int unsigned mid;
    total = used_width() * used_height();
    res = '{default: 0};
    case (act)
      ACT_LOAD: begin
        if (pixels_loaded < total && pixels_loaded < StoreSize) begin
          pixel_copy[pixels_loaded] = px;
          pixels_loaded++;
        end
        return 1'b0;
      end
      ACT_RESTART: begin
        pixels_loaded = 0;
        span_count = 0;
        splitting_started = 1'b0;
        return 1'b0;
      end
      ACT_FETCH: ;
      default: return 1'b0;
    endcase
    res.none = 1'b1;
    if (pixels_loaded < total) return 1'b1;
    if (!splitting_started) begin
      splitting_started = 1'b1;
      span_count = 0;
      push_span(0, used_width() - 1, 0, used_height() - 1);
    end
    while (span_count > 0) begin
      span_count--;
      r = span_stack[span_count];
      w = longint'(r.x1) - r.x0 + 1;
      h = longint'(r.y1) - r.y0 + 1;
      area = w * h;
      if (area == 1 || area <= shadow_cfg.smallest_bin_area ||
          span_count + 2 > StackDepthDefault || region_is_dim(r)) begin
        res.x_first = r.x0[7:0];
        res.x_last = r.x1[7:0];
        res.y_first = r.y0[6:0];
        res.y_last = r.y1[6:0];
        res.last = (span_count == 0);
        res.none = 1'b0;
        return 1'b1;
      end
      if (w > h) begin
        mid = int'((w - 1) / 2) + r.x0;
        push_span(mid + 1, r.x1, r.y0, r.y1);
        push_span(r.x0, mid, r.y0, r.y1);
      end else begin
        mid = int'((h - 1) / 2) + r.y0;
        push_span(r.x0, r.x1, mid + 1, r.y1);
        push_span(r.x0, r.x1, r.y0, mid);
      end
    end
    return 1'b1;
  endfunction

  function automatic int draw_wait();
    if (quiet) return 0;
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, 14);
  endfunction

  task automatic send_word(action_t act, pixel_t px);
    int gap;
    bin_word_t res;
    gap = draw_wait();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.red <= px.red;
    in_ch.green <= px.green;
    in_ch.blue <= px.blue;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
    if (predict_word(act, px, res)) begin
      expected_bins = {expected_bins, res};
      fetch_gave_none = res.none;
    end
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (expected_bins.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_WIDTH: shadow_cfg.image_width = value[8:0];
      REG_HEIGHT: shadow_cfg.image_height = value[7:0];
      REG_RADIANCE: shadow_cfg.min_radiance = value;
      default: shadow_cfg.smallest_bin_area = value[15:0];
    endcase
  endtask

  task automatic set_image(logic [31:0] w, logic [31:0] h, logic [31:0] rad,
                           logic [31:0] area);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_RADIANCE, rad);
    write_reg(REG_AREA, area);
  endtask

  function automatic pixel_t make_pixel(int mode);
    pixel_t p;
    case (mode)
      0: p = '{$urandom_range(0, 32'h0001_0000), $urandom_range(0, 32'h0001_0000),
               $urandom_range(0, 32'h0001_0000)};
      1: p = '{$urandom(), $urandom(), $urandom()};
      2: begin
        if ($urandom_range(0, 3) == 0) p = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        else p = '0;
      end
      default: p = '{$urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255)};
    endcase
    return p;
  endfunction

  task automatic load_image(int mode);
    int unsigned total;
    total = used_width() * used_height();
    send_word(ACT_RESTART, '0);
    for (int unsigned i = 0; i < total; i++) send_word(ACT_LOAD, make_pixel(mode));
  endtask

  task automatic fetch_all(int most);
    for (int i = 0; i < most; i++) begin
      send_word(ACT_FETCH, '0);
      if (fetch_gave_none) break;
    end
  endtask

  task automatic test_unloaded_fetch();
    send_word(ACT_FETCH, '0);
    send_word(ACT_NONE, '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    send_word(ACT_LOAD, '{32'h1, 32'h2, 32'h3});
    send_word(ACT_FETCH, '0);
    send_word(ACT_RESTART, '0);
    settle();
  endtask

  task automatic test_single_pixel();
    set_image(0, 0, 32'hFFFF_FFFF, 32'hFFFF);
    send_word(ACT_RESTART, '0);
    send_word(ACT_LOAD, '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    send_word(ACT_LOAD, '{32'h5, 32'h5, 32'h5});
    send_word(ACT_FETCH, '0);
    send_word(ACT_FETCH, '0);
    send_word(ACT_FETCH, '0);
    settle();
  endtask

  task automatic test_wide_row();
    set_image(511, 1, 0, 32);
    load_image(0);
    fetch_all(20);
    settle();
  endtask

  task automatic test_tall_column();
    set_image(1, 255, 32'hFFFF_FFFF, 1);
    load_image(2);
    fetch_all(140);
    settle();
  endtask

  task automatic test_width_change();
    set_image(8, 4, 32'h0000_8000, 1);
    load_image(3);
    fetch_all(3);
    settle();
    write_reg(REG_WIDTH, 4);
    fetch_all(40);
    settle();
  endtask

  task automatic test_output_stall();
    set_image(6, 4, 0, 1);
    load_image(1);
    hold_off_cycles = 400;
    fetch_all(6);
    quiet = 1'b1;
    fetch_all(30);
    quiet = 1'b0;
    settle();
  endtask

  task automatic test_random();
    int unsigned w, h, mode;
    logic [31:0] rad;
    while (words_sent < RandomWords) begin
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
      h = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
      case ($urandom_range(0, 3))
        0: rad = 0;
        1: rad = $urandom();
        default: rad = $urandom_range(0, 32'h0004_0000);
      endcase
      mode = $urandom_range(0, 3);
      set_image(w, h, rad, ($urandom_range(0, 1) == 0) ? 1 : $urandom_range(1, w * h));
      quiet = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 3) == 0) send_word(ACT_FETCH, '0);
      send_word(ACT_RESTART, '0);
      for (int unsigned i = 0; i < w * h; i++) begin
        if ($urandom_range(0, 19) == 0) send_word(ACT_NONE, make_pixel(1));
        send_word(ACT_LOAD, make_pixel(mode));
      end
      repeat ($urandom_range(0, 2)) send_word(ACT_LOAD, make_pixel(1));
      fetch_all(($urandom_range(0, 5) == 0) ? $urandom_range(1, 4) : 60);
      if (fetch_gave_none) repeat ($urandom_range(0, 2)) send_word(ACT_FETCH, '0);
      quiet = 1'b0;
      settle();
    end
  endtask

  initial begin
    out_ch.ready <= 1'b1;
    forever begin
      int n;
      if (hold_off_cycles > 0) begin
        n = hold_off_cycles;
        hold_off_cycles = 0;
      end else begin
        n = draw_wait();
      end
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_bins.size() == 0) begin
        errors++;
        $display("%0t: unexpected bin word x %0d..%0d y %0d..%0d last %b none %b", $time,
                 out_ch.bin_x_first, out_ch.bin_x_last, out_ch.bin_y_first,
                 out_ch.bin_y_last, out_ch.last_bin, out_ch.no_bin);
      end else begin
        bin_word_t e;
        e = expected_bins.pop_front();
        bins_checked++;
        if (!e.none) bins_real++;
        if (out_ch.bin_x_first !== e.x_first || out_ch.bin_x_last !== e.x_last ||
            out_ch.bin_y_first !== e.y_first || out_ch.bin_y_last !== e.y_last ||
            out_ch.last_bin !== e.last || out_ch.no_bin !== e.none) begin
          errors++;
          $display("%0t: bin mismatch, expected x %0d..%0d y %0d..%0d last %b none %b,",
                   $time, e.x_first, e.x_last, e.y_first, e.y_last, e.last, e.none);
          $display("   actual x %0d..%0d y %0d..%0d last %b none %b", out_ch.bin_x_first,
                   out_ch.bin_x_last, out_ch.bin_y_first, out_ch.bin_y_last,
                   out_ch.last_bin, out_ch.no_bin);
        end
      end
    end
  end

  initial begin
    cycles = 0;
    errors = 0;
    words_sent = 0;
    bins_checked = 0;
    bins_real = 0;
    quiet = 1'b0;
    hold_off_cycles = 0;
    fetch_gave_none = 1'b0;
    pixels_loaded = 0;
    span_count = 0;
    splitting_started = 1'b0;
    shadow_cfg = '{9'd256, 8'd128, 32'd65536, 16'd1};
    for (int i = 0; i < StoreSize; i++) pixel_copy[i] = '0;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_WIDTH;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.action <= ACT_NONE;
    in_ch.red <= '0;
    in_ch.green <= '0;
    in_ch.blue <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_unloaded_fetch();
    test_single_pixel();
    test_wide_row();
    test_tall_column();
    test_width_change();
    test_output_stall();
    test_random();
    settle();
    repeat (50) @(posedge clk);
    $display("Sent %0d words; checked %0d result words, %0d of them real bins.",
             words_sent, bins_checked, bins_real);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches found.", errors);
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
